@@ rtl/vpc_pkg.sv @@
// Shared types and constants for the trapezoidal velocity profiler.
// Used by the configuration register file, the step datapath and the top level.
// No dependencies.
package vpc_pkg;

    localparam int VEL_W     = 32;  // signed Q16.16 velocity
    localparam int UQ_W      = 31;  // unsigned Q15.16 velocity or distance
    localparam int GAIN_W    = 24;  // unsigned Q8.16 gain
    localparam int ERR_W     = 18;  // accumulated velocity error
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [ERR_W-1:0] ERR_CAP = ERR_W'(196608);  // 3.0 in Q2.16

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VELOCITY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_KP       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_KI       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DECEL_START    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_DISTANCE  = 3'd6;

    typedef enum logic [1:0] {
        PH_ACCEL = 2'd0,
        PH_CONST = 2'd1,
        PH_DECEL = 2'd2
    } t_phase;

    typedef struct packed {
        logic [UQ_W-1:0]   max_velocity;
        logic [UQ_W-1:0]   min_velocity;
        logic [GAIN_W-1:0] accel_prop_gain;
        logic [GAIN_W-1:0] accel_integral_gain;
        logic [GAIN_W-1:0] decel_distance_gain;
        logic [UQ_W-1:0]   decel_start_distance;
        logic [UQ_W-1:0]   stop_distance;
    } t_cfg;

    typedef struct packed {
        t_phase            motion_phase;
        logic [ERR_W-1:0]  error_sum;
        logic [VEL_W-1:0]  decel_entry_speed;
    } t_state;

endpackage

@@ rtl/vpc_cfg_regs.sv @@
// Configuration register file of the velocity profiler.
// Depends on vpc_pkg for the register indexes and the t_cfg struct.
module vpc_cfg_regs import vpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                 o_cfg_ready,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_MAX_VELOCITY:  n_cfg.max_velocity         = i_cfg_data[UQ_W-1:0];
                REG_MIN_VELOCITY:  n_cfg.min_velocity         = i_cfg_data[UQ_W-1:0];
                REG_ACCEL_KP:      n_cfg.accel_prop_gain      = i_cfg_data[GAIN_W-1:0];
                REG_ACCEL_KI:      n_cfg.accel_integral_gain  = i_cfg_data[GAIN_W-1:0];
                REG_DECEL_GAIN:    n_cfg.decel_distance_gain  = i_cfg_data[GAIN_W-1:0];
                REG_DECEL_START:   n_cfg.decel_start_distance = i_cfg_data[UQ_W-1:0];
                REG_STOP_DISTANCE: n_cfg.stop_distance        = i_cfg_data[UQ_W-1:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_velocity         <= UQ_W'(32768);
            r_cfg.min_velocity         <= UQ_W'(6554);
            r_cfg.accel_prop_gain      <= GAIN_W'(32768);
            r_cfg.accel_integral_gain  <= GAIN_W'(45875);
            r_cfg.decel_distance_gain  <= GAIN_W'(196608);
            r_cfg.decel_start_distance <= UQ_W'(6554);
            r_cfg.stop_distance        <= UQ_W'(1966);
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ rtl/vpc_step_core.sv @@
// Combinational datapath for one profiler item: PI boost, deceleration ramp,
// phase transitions and the next profiler state. Depends on vpc_pkg.
module vpc_step_core import vpc_pkg::*; (
    input  t_cfg              i_cfg,
    input  t_state            i_state,
    input  logic              i_op,
    input  logic              i_start_constant,
    input  logic [VEL_W-1:0]  i_velocity_in,
    input  logic [UQ_W-1:0]   i_remaining_distance,
    output t_state            o_state,
    output logic [VEL_W-1:0]  o_velocity_out
);

    // Accelerate path
    logic signed [VEL_W:0]     diff;
    logic [VEL_W-1:0]          diff_mag;
    logic [GAIN_W+VEL_W-1:0]   kp_prod;
    logic [GAIN_W+ERR_W-1:0]   ki_prod;
    logic signed [42:0]        acc_sum;
    logic signed [42:0]        vmax_wide;
    logic                      acc_reached;
    logic [VEL_W-1:0]          acc_v;
    logic signed [VEL_W+1:0]   err_gap;
    logic [VEL_W+1:0]          err_wide;
    logic [ERR_W-1:0]          acc_err;

    // Decelerate path
    logic [GAIN_W+UQ_W-1:0]    dec_prod;
    logic signed [40:0]        dec_prop;
    logic signed [40:0]        dec_entry;
    logic signed [40:0]        dec_vmax;
    logic signed [40:0]        dec_lim1;
    logic signed [40:0]        dec_lim2;
    logic [VEL_W-1:0]          dec_v;

    logic near_target;

    assign near_target = i_remaining_distance < i_cfg.decel_start_distance;

    always_comb begin
        diff     = $signed({i_velocity_in[VEL_W-1], i_velocity_in})
                 - $signed({2'b00, i_cfg.max_velocity});
        diff_mag = diff[VEL_W] ? VEL_W'(-diff) : diff[VEL_W-1:0];
        kp_prod  = (GAIN_W+VEL_W)'(i_cfg.accel_prop_gain) * (GAIN_W+VEL_W)'(diff_mag);
        ki_prod  = (GAIN_W+ERR_W)'(i_cfg.accel_integral_gain)
                 * (GAIN_W+ERR_W)'(i_state.error_sum);

        // Products are truncated to Q16.16 by dropping the low 16 bits.
        acc_sum  = $signed({{11{i_velocity_in[VEL_W-1]}}, i_velocity_in})
                 + $signed({3'b000, kp_prod[GAIN_W+VEL_W-1:16]})
                 + $signed({17'd0, ki_prod[GAIN_W+ERR_W-1:16]});
        vmax_wide   = $signed({12'd0, i_cfg.max_velocity});
        acc_reached = !(acc_sum < vmax_wide);
        acc_v       = acc_reached ? {1'b0, i_cfg.max_velocity} : acc_sum[VEL_W-1:0];

        // The gap to the maximum is never negative because acc_v is clipped.
        err_gap  = $signed({3'b000, i_cfg.max_velocity}) - $signed({{2{acc_v[VEL_W-1]}}, acc_v});
        err_wide = (VEL_W+2)'(i_state.error_sum) + err_gap;
        acc_err  = (err_wide >= (VEL_W+2)'(ERR_CAP)) ? ERR_CAP : err_wide[ERR_W-1:0];
    end

    always_comb begin
        dec_prod  = (GAIN_W+UQ_W)'(i_cfg.decel_distance_gain)
                  * (GAIN_W+UQ_W)'(i_remaining_distance);
        dec_prop  = $signed({2'b00, dec_prod[GAIN_W+UQ_W-1:16]});
        dec_entry = $signed({{9{i_state.decel_entry_speed[VEL_W-1]}},
                             i_state.decel_entry_speed});
        dec_vmax  = $signed({10'd0, i_cfg.max_velocity});
        dec_lim1  = (dec_prop < dec_entry) ? dec_prop : dec_entry;
        dec_lim2  = (dec_lim1 < dec_vmax) ? dec_lim1 : dec_vmax;
        if (i_remaining_distance <= i_cfg.stop_distance) begin
            dec_v = '0;
        end else if (dec_lim2 < $signed({10'd0, i_cfg.min_velocity})) begin
            dec_v = {1'b0, i_cfg.min_velocity};
        end else begin
            dec_v = dec_lim2[VEL_W-1:0];
        end
    end

    always_comb begin
        o_state        = i_state;
        o_velocity_out = dec_v;
        if (i_op == OP_START) begin
            o_state.motion_phase = i_start_constant ? PH_CONST : PH_ACCEL;
            o_state.error_sum    = '0;
        end else begin
            unique case (i_state.motion_phase)
                PH_ACCEL: begin
                    o_velocity_out    = acc_v;
                    o_state.error_sum = acc_err;
                    if (acc_reached) begin
                        o_state.motion_phase = PH_CONST;
                    end else if (near_target) begin
                        o_state.decel_entry_speed = acc_v;
                        o_state.motion_phase      = PH_DECEL;
                    end
                end
                PH_CONST: begin
                    o_velocity_out = {1'b0, i_cfg.max_velocity};
                    if (near_target) begin
                        o_state.decel_entry_speed = {1'b0, i_cfg.max_velocity};
                        o_state.motion_phase      = PH_DECEL;
                    end
                end
                default: begin
                    o_velocity_out = dec_v;
                end
            endcase
        end
    end

endmodule

@@ rtl/velocity_profile_controller_top.sv @@
// Top level of the trapezoidal velocity profiler: input register, profiler
// state, result register. Depends on vpc_pkg, vpc_cfg_regs and vpc_step_core.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one item per beat. A start
//   beat (op = 0) selects the first phase and clears the error sum; it yields
//   no result. A step beat (op = 1) yields exactly one result beat on the
//   output channel (o_out_valid / i_out_ready): the new velocity command and
//   the phase after the step.
//   Configuration beats (i_cfg_valid / o_cfg_ready) write register i_cfg_index
//   with i_cfg_data; the port is always ready and unknown indexes are ignored.
//   Write configuration only while no item is in flight.
//   Throughput: one item per cycle while the receiver takes results; the whole
//   step (PI boost, deceleration ramp, phase update) is combinational logic
//   between the input register and the result register.
//   When the receiver stalls, the result register holds and the input register
//   fills, after which o_in_ready drops; start beats still drain since they
//   need no result slot.
//   Reset (synchronous, active low) empties both registers, returns to the
//   accelerate phase with zero error sum and entry speed, and restores the
//   default configuration.
module velocity_profile_controller_top import vpc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_op,
    input  logic                 i_start_constant,
    input  logic [VEL_W-1:0]     i_velocity_in,
    input  logic [UQ_W-1:0]      i_remaining_distance,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [VEL_W-1:0]     o_velocity_out,
    output logic [1:0]           o_phase,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg   cfg;
    t_state r_state;
    t_state n_state;

    logic              r_in_valid;
    logic              r_op;
    logic              r_start_constant;
    logic [VEL_W-1:0]  r_velocity_in;
    logic [UQ_W-1:0]   r_remaining_distance;

    logic              r_out_valid;
    logic [VEL_W-1:0]  r_velocity_out;
    t_phase            r_phase;
    logic [VEL_W-1:0]  n_velocity_out;

    logic out_free;
    logic fire;

    vpc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (cfg)
    );

    vpc_step_core u_core (
        .i_cfg                (cfg),
        .i_state              (r_state),
        .i_op                 (r_op),
        .i_start_constant     (r_start_constant),
        .i_velocity_in        (r_velocity_in),
        .i_remaining_distance (r_remaining_distance),
        .o_state              (n_state),
        .o_velocity_out       (n_velocity_out)
    );

    // A start beat needs no result slot, so it retires even while stalled.
    assign out_free   = !r_out_valid || i_out_ready;
    assign fire       = r_in_valid && ((r_op == OP_START) || out_free);
    assign o_in_ready = !r_in_valid || fire;

    assign o_out_valid    = r_out_valid;
    assign o_velocity_out = r_velocity_out;
    assign o_phase        = r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op                 <= i_op;
            r_start_constant     <= i_start_constant;
            r_velocity_in        <= i_velocity_in;
            r_remaining_distance <= i_remaining_distance;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.motion_phase      <= PH_ACCEL;
            r_state.error_sum         <= '0;
            r_state.decel_entry_speed <= '0;
        end else if (fire) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && (r_op == OP_STEP)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && (r_op == OP_STEP)) begin
            r_velocity_out <= n_velocity_out;
            r_phase        <= n_state.motion_phase;
        end
    end

endmodule
